FILE: sv/rvx_pkg.sv
// ----------------------------------------------------------------------------
// rvx_pkg
// Shared constants, codes and types of the RV32I subset executor.
// ----------------------------------------------------------------------------
package rvx_pkg;

	localparam int DATA_BYTES_DEF = 1024;
	localparam int REG_COUNT      = 32;

	localparam int IN_TDATA_W  = 56;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_FIELD_W = 146;
	localparam int OUT_TDATA_W = 152;
	localparam int HALT_BIT    = 32;

	localparam logic [6:0] OP_BRANCH = 7'b1100011;
	localparam logic [6:0] OP_REG    = 7'b0110011;
	localparam logic [6:0] OP_IMM    = 7'b0010011;
	localparam logic [6:0] OP_LOAD   = 7'b0000011;
	localparam logic [6:0] OP_STORE  = 7'b0100011;
	localparam logic [6:0] OP_JAL    = 7'b1101111;
	localparam logic [6:0] OP_HALT   = 7'b1111111;

	localparam logic [6:0] F7_BASE = 7'b0000000;
	localparam logic [6:0] F7_ALT  = 7'b0100000;

	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;
	localparam logic [2:0] F3_WORD = 3'd2;
	localparam logic [2:0] F3_BEQ  = 3'd0;
	localparam logic [2:0] F3_BNE  = 3'd1;

	typedef enum logic [1:0] {
		ACT_EXEC,
		ACT_WR_BYTE,
		ACT_RD_BYTE,
		ACT_RD_REG
	} action_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_WRAP,
		S_LOAD,
		S_STORE,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic [31:0] store_value;
		logic [9:0]  store_address;
		logic        did_store;
		logic [31:0] dest_value;
		logic [4:0]  dest_index;
		logic        wrote_register;
		logic        halted;
		logic [31:0] next_pc;
	} result_t;

endpackage

FILE: sv/rvx_addr_wrap.sv
// ----------------------------------------------------------------------------
// rvx_addr_wrap
// Reduces a 32-bit byte address modulo the data memory size: a plain mask
// for a power-of-two size, otherwise a bit-serial remainder over the 32 bits.
// ----------------------------------------------------------------------------
module rvx_addr_wrap #(
	parameter int DATA_BYTES = rvx_pkg::DATA_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [31:0]                   raw,
	output logic                          done,
	output logic [$clog2(DATA_BYTES)-1:0] base
);
	import rvx_pkg::*;

	localparam int         AW   = $clog2(DATA_BYTES);
	localparam bit         POW2 = (DATA_BYTES & (DATA_BYTES - 1)) == 0;
	localparam logic [AW:0] MODV = (AW + 1)'(DATA_BYTES);

	logic [31:0]   raw_q;
	logic [AW-1:0] rem_q;
	logic [4:0]    bit_q;
	logic          run_q;
	logic          done_q;
	logic [AW:0]   rem_cat;
	logic [AW-1:0] rem_nxt;

	always_comb begin
		rem_cat = {rem_q, raw_q[bit_q]};
		if (rem_cat >= MODV) begin
			rem_nxt = AW'(rem_cat - MODV);
		end else begin
			rem_nxt = rem_cat[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (POW2) begin
					done_q <= 1'b1;
				end else begin
					run_q <= 1'b1;
					bit_q <= 5'd31;
				end
			end else if (run_q) begin
				bit_q <= bit_q - 5'd1;
				if (bit_q == 5'd0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			raw_q <= raw;
			rem_q <= POW2 ? raw[AW-1:0] : '0;
		end else if (run_q) begin
			rem_q <= rem_nxt;
		end
	end

	assign done = done_q;
	assign base = rem_q;

endmodule

FILE: sv/rv32i_subset_executor_unit.sv
// ----------------------------------------------------------------------------
// rv32i_subset_executor_unit
// Executes RV32I subset instructions against a register file memory and a
// big-endian byte data memory; also preloads and reads back state.
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out. Register reads, ALU ops,
// branches, jal and halt pass through the registered read of the register
// file memory and then the result stage. Byte writes and reads, sw and lw
// go through the single byte port of the data memory after an address
// reduction step: a mask when DATA_BYTES is a power of two, a bit-serial
// remainder otherwise. After reset a clearing pass zeroes both memories; no
// input is taken during it. A finished result waits in the output register
// while the next transaction is taken.
module rv32i_subset_executor_unit #(
	parameter int DATA_BYTES = rvx_pkg::DATA_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// instruction_word, byte_address, byte_value, reg_index
	input  logic [rvx_pkg::IN_TDATA_W-1:0]  s_tdata,
	// action
	input  logic [rvx_pkg::IN_TUSER_W-1:0]  s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// next_pc, halted, wrote_register, dest_index, dest_value, did_store,
	// store_address, store_value, read_data
	output logic [rvx_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import rvx_pkg::*;

	localparam int AW    = $clog2(DATA_BYTES);
	localparam int CLR_N = (DATA_BYTES > REG_COUNT) ? DATA_BYTES : REG_COUNT;
	localparam int CW    = $clog2(CLR_N);
	localparam logic [CW-1:0] CLR_LAST  = CW'(CLR_N - 1);
	localparam logic [CW:0]   CLR_DM    = (CW + 1)'(DATA_BYTES);
	localparam logic [CW:0]   CLR_RF    = (CW + 1)'(REG_COUNT);
	localparam logic [AW-1:0] ADDR_LAST = AW'(DATA_BYTES - 1);

	state_t  state_q, state_d;

	action_t     act_q;
	logic [31:0] word_q;
	logic [9:0]  baddr_q;
	logic [7:0]  bval_q;
	logic [4:0]  ridx_q;

	logic [31:0] pc_q;
	logic        halt_q;
	logic [CW-1:0] clr_q;
	logic [2:0]  cnt_q;
	logic [1:0]  lim_q;
	logic        is_load_q;
	logic        mem_wr_q;
	logic [AW-1:0] byte_addr_q;
	logic [23:0] load_q;
	logic [31:0] st_sh_q;
	result_t     res_q;
	result_t     out_q;
	logic        out_valid_q;

	logic [31:0] rf_mem [REG_COUNT];
	logic [31:0] rf_a_q, rf_b_q;
	logic [7:0]  dm_mem [DATA_BYTES];
	logic [7:0]  dm_rd_q;

	logic        in_acc;
	logic        out_free;
	action_t     in_act;
	logic [4:0]  rf_ra, rf_rb;
	logic        rf_we;
	logic [4:0]  rf_wa;
	logic [31:0] rf_wd;
	logic        dm_we;
	logic [AW-1:0] dm_wa;
	logic [7:0]  dm_wd;
	logic        wrap_start;
	logic [31:0] wrap_raw;
	logic        wrap_done;
	logic [AW-1:0] wrap_base;

	logic [6:0]  op;
	logic [2:0]  f3;
	logic [6:0]  f7;
	logic [4:0]  rd;
	logic [31:0] immi, imms, immb, immj, pc_plus4;
	logic        ex_wr, ex_halt, ex_load, ex_store;
	logic [31:0] ex_val, ex_npc, mem_raw;
	logic        ex_commit;
	logic        load_last;
	logic [31:0] load_word;
	logic [AW-1:0] addr_next;
	result_t     res_full;

	assign in_act   = action_t'(s_tuser);
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign rf_ra    = (in_act == ACT_RD_REG) ? s_tdata[54:50] : s_tdata[19:15];
	assign rf_rb    = s_tdata[24:20];

	assign op       = word_q[6:0];
	assign f3       = word_q[14:12];
	assign f7       = word_q[31:25];
	assign rd       = word_q[11:7];
	assign immi     = {{20{word_q[31]}}, word_q[31:20]};
	assign imms     = {{20{word_q[31]}}, word_q[31:25], word_q[11:7]};
	assign immb     = {{19{word_q[31]}}, word_q[31], word_q[7], word_q[30:25],
		word_q[11:8], 1'b0};
	assign immj     = {{11{word_q[31]}}, word_q[31], word_q[19:12], word_q[20],
		word_q[30:21], 1'b0};
	assign pc_plus4 = pc_q + 32'd4;
	assign mem_raw  = rf_a_q + (ex_store ? imms : immi);

	assign ex_commit = (state_q == S_READ) && (act_q == ACT_EXEC) && !halt_q;
	assign load_last = (cnt_q == ({1'b0, lim_q} + 3'd1));
	assign load_word = {load_q, dm_rd_q};
	assign addr_next = (byte_addr_q == ADDR_LAST) ? '0 : byte_addr_q + 1'b1;

	always_comb begin
		ex_wr    = 1'b0;
		ex_val   = '0;
		ex_npc   = pc_plus4;
		ex_halt  = 1'b0;
		ex_load  = 1'b0;
		ex_store = 1'b0;
		unique case (op)
			OP_HALT: begin
				ex_halt = 1'b1;
				ex_npc  = pc_q;
			end
			OP_REG: begin
				if (f3 == F3_ADD && f7 == F7_BASE) begin
					ex_wr  = 1'b1;
					ex_val = rf_a_q + rf_b_q;
				end else if (f3 == F3_ADD && f7 == F7_ALT) begin
					ex_wr  = 1'b1;
					ex_val = rf_a_q - rf_b_q;
				end else if (f3 == F3_XOR && f7 == F7_BASE) begin
					ex_wr  = 1'b1;
					ex_val = rf_a_q ^ rf_b_q;
				end else if (f3 == F3_OR && f7 == F7_BASE) begin
					ex_wr  = 1'b1;
					ex_val = rf_a_q | rf_b_q;
				end else if (f3 == F3_AND && f7 == F7_BASE) begin
					ex_wr  = 1'b1;
					ex_val = rf_a_q & rf_b_q;
				end
			end
			OP_IMM: begin
				unique case (f3)
					F3_ADD: begin
						ex_wr  = 1'b1;
						ex_val = rf_a_q + immi;
					end
					F3_XOR: begin
						ex_wr  = 1'b1;
						ex_val = rf_a_q ^ immi;
					end
					F3_OR: begin
						ex_wr  = 1'b1;
						ex_val = rf_a_q | immi;
					end
					F3_AND: begin
						ex_wr  = 1'b1;
						ex_val = rf_a_q & immi;
					end
					default: ;
				endcase
			end
			OP_LOAD: ex_load = (f3 == F3_WORD);
			OP_STORE: ex_store = (f3 == F3_WORD);
			OP_BRANCH: begin
				if ((f3 == F3_BEQ && rf_a_q == rf_b_q) ||
					(f3 == F3_BNE && rf_a_q != rf_b_q)) begin
					ex_npc = pc_q + immb;
				end
			end
			OP_JAL: begin
				ex_wr  = 1'b1;
				ex_val = pc_plus4;
				ex_npc = pc_q + immj;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		rf_we      = 1'b0;
		rf_wa      = rd;
		rf_wd      = ex_val;
		dm_we      = 1'b0;
		dm_wa      = byte_addr_q;
		dm_wd      = st_sh_q[31:24];
		wrap_start = 1'b0;
		wrap_raw   = mem_raw;
		unique case (state_q)
			S_CLEAR: begin
				rf_we = ({1'b0, clr_q} < CLR_RF);
				rf_wa = clr_q[4:0];
				rf_wd = '0;
				dm_we = ({1'b0, clr_q} < CLR_DM);
				dm_wa = clr_q[AW-1:0];
				dm_wd = '0;
				if (clr_q == CLR_LAST) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				unique case (act_q)
					ACT_RD_REG: state_d = S_DONE;
					ACT_WR_BYTE, ACT_RD_BYTE: begin
						wrap_start = 1'b1;
						wrap_raw   = 32'(baddr_q);
						state_d    = S_WRAP;
					end
					ACT_EXEC: begin
						if (halt_q) begin
							state_d = S_DONE;
						end else if (ex_load || ex_store) begin
							wrap_start = 1'b1;
							state_d    = S_WRAP;
						end else begin
							rf_we   = ex_wr && (rd != 5'd0);
							state_d = S_DONE;
						end
					end
					default: state_d = S_DONE;
				endcase
			end
			S_WRAP: begin
				if (wrap_done) begin
					state_d = mem_wr_q ? S_STORE : S_LOAD;
				end
			end
			S_LOAD: begin
				if (load_last) begin
					rf_we   = is_load_q && (rd != 5'd0);
					rf_wd   = load_word;
					state_d = S_DONE;
				end
			end
			S_STORE: begin
				dm_we = 1'b1;
				if (cnt_q[1:0] == lim_q) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				s_tready = out_free;
				if (out_free) begin
					state_d = s_tvalid ? S_READ : S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rf_we) begin
			rf_mem[rf_wa] <= rf_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			rf_a_q <= rf_mem[rf_ra];
			rf_b_q <= rf_mem[rf_rb];
		end
	end

	always_ff @(posedge clk) begin
		if (dm_we) begin
			dm_mem[dm_wa] <= dm_wd;
		end
	end

	always_ff @(posedge clk) begin
		dm_rd_q <= dm_mem[byte_addr_q];
	end

	rvx_addr_wrap #(
		.DATA_BYTES(DATA_BYTES)
	) u_wrap (
		.clk   (clk),
		.arst_n(arst_n),
		.start (wrap_start),
		.raw   (wrap_raw),
		.done  (wrap_done),
		.base  (wrap_base)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= '0;
			halt_q      <= 1'b0;
			clr_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (ex_commit) begin
				pc_q <= ex_npc;
				if (ex_halt) begin
					halt_q <= 1'b1;
				end
			end
			if (state_q == S_WRAP) begin
				cnt_q <= '0;
			end else if (state_q == S_LOAD || state_q == S_STORE) begin
				cnt_q <= cnt_q + 3'd1;
			end
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		res_full         = res_q;
		res_full.next_pc = pc_q;
		res_full.halted  = halt_q;
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			act_q   <= in_act;
			word_q  <= s_tdata[31:0];
			baddr_q <= s_tdata[41:32];
			bval_q  <= s_tdata[49:42];
			ridx_q  <= s_tdata[54:50];
		end
		case (state_q)
			S_READ: begin
				res_q     <= '0;
				is_load_q <= (act_q == ACT_EXEC);
				mem_wr_q  <= 1'b0;
				lim_q     <= 2'd0;
				st_sh_q   <= {bval_q, 24'd0};
				if (act_q == ACT_RD_REG) begin
					res_q.read_data <= (ridx_q != 5'd0) ? rf_a_q : '0;
				end else if (act_q == ACT_WR_BYTE) begin
					mem_wr_q <= 1'b1;
				end else if (ex_commit) begin
					if (ex_load) begin
						lim_q <= 2'd3;
					end else if (ex_store) begin
						lim_q             <= 2'd3;
						mem_wr_q          <= 1'b1;
						st_sh_q           <= rf_b_q;
						res_q.did_store   <= 1'b1;
						res_q.store_value <= rf_b_q;
					end else if (ex_wr && rd != 5'd0) begin
						res_q.wrote_register <= 1'b1;
						res_q.dest_index     <= rd;
						res_q.dest_value     <= ex_val;
					end
				end
			end
			S_WRAP: begin
				byte_addr_q <= wrap_base;
				load_q      <= '0;
				if (res_q.did_store) begin
					res_q.store_address <= 10'(wrap_base);
				end
			end
			S_LOAD: begin
				byte_addr_q <= addr_next;
				if (cnt_q != 3'd0) begin
					load_q <= {load_q[15:0], dm_rd_q};
				end
				if (load_last) begin
					if (!is_load_q) begin
						res_q.read_data <= load_word;
					end else if (rd != 5'd0) begin
						res_q.wrote_register <= 1'b1;
						res_q.dest_index     <= rd;
						res_q.dest_value     <= load_word;
					end
				end
			end
			S_STORE: begin
				byte_addr_q <= addr_next;
				st_sh_q     <= {st_sh_q[23:0], 8'd0};
			end
			S_DONE: begin
				if (out_free) begin
					out_q <= res_full;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(OUT_TDATA_W - OUT_FIELD_W)'(0), out_q};

endmodule

FILE: sv/rvx_checker.sv
// ----------------------------------------------------------------------------
// rvx_checker
// Port-level checks of the RV32I subset executor, bound to its top level.
// ----------------------------------------------------------------------------
module rvx_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [rvx_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import rvx_pkg::*;

	logic [1:0] pend_q;
	logic       halt_seen_q;
	logic       s_acc, m_acc;

	assign s_acc = s_tvalid && s_tready;
	assign m_acc = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= '0;
			halt_seen_q <= 1'b0;
		end else begin
			pend_q <= pend_q + {1'b0, s_acc} - {1'b0, m_acc};
			if (m_acc && m_tdata[HALT_BIT]) begin
				halt_seen_q <= 1'b1;
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output transaction changed while stalled");

	a_out_has_in: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pend_q != 2'd0)
		else $error("output transaction without an input transaction");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("more than two transactions in flight");

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && halt_seen_q |-> m_tdata[HALT_BIT])
		else $error("halt flag cleared after it was reported");

endmodule

bind rv32i_subset_executor_unit rvx_checker u_rvx_checker (.*);

FILE: tb/rv32i_subset_executor_unit_tb.sv
// ----------------------------------------------------------------------------
// rv32i_subset_executor_unit_tb
// Drives instruction and memory-access transactions into the executor and
// checks every result against a cycle-free shadow of the register file, data
// memory, program counter and halt flag. Directed corner cases come first,
// then constrained-by-hand random programs, then the halt sequence.
// ----------------------------------------------------------------------------
module rv32i_subset_executor_unit_tb;
	import rvx_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DATA_BYTES = DATA_BYTES_DEF;
	localparam int RANDOM_ITEMS = 620;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		action_t     act;
		logic [31:0] insn;
		logic [9:0]  baddr;
		logic [7:0]  bval;
		logic [4:0]  ridx;
	} item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic [IN_TUSER_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	item_t items_pending[$];
	result_t results_due[$];
	item_t on_bus;

	logic [31:0] shadow_gpr [REG_COUNT];
	logic [7:0] shadow_mem [DATA_BYTES];
	logic [31:0] shadow_pc;
	logic shadow_halt;

	int items_total;
	int items_accepted;
	int results_seen;
	int errors;
	int cycles;
	int hold_left;
	bit hold_done;
	int n_exec, n_reg_writes, n_stores, n_loads, n_redirects;

	rv32i_subset_executor_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #1 clk = ~clk;

	function automatic logic [31:0] mem_word(input logic [31:0] addr);
		logic [31:0] word;
		word = '0;
		for (int i = 0; i < 4; i++)
			word = {word[23:0], shadow_mem[(addr + 32'(i)) % 32'(DATA_BYTES)]};
		return word;
	endfunction

	function automatic result_t run_on_shadow_cpu(input item_t it);
		result_t r;
		logic [31:0] w, a, b, npc, immi, imms, immb, immj, val, ea;
		logic [6:0] op, f7;
		logic [2:0] f3;
		logic [4:0] rd;
		logic wr;
		r = '0;
		wr = 1'b0;
		val = '0;
		w = it.insn;
		case (it.act)
			ACT_WR_BYTE: shadow_mem[int'(it.baddr) % DATA_BYTES] = it.bval;
			ACT_RD_BYTE: r.read_data = {24'd0, shadow_mem[int'(it.baddr) % DATA_BYTES]};
			ACT_RD_REG: r.read_data = (it.ridx == 5'd0) ? 32'd0 : shadow_gpr[it.ridx];
			default: begin
				if (!shadow_halt) begin
					n_exec++;
					op = w[6:0];
					f3 = w[14:12];
					f7 = w[31:25];
					rd = w[11:7];
					a = shadow_gpr[w[19:15]];
					b = shadow_gpr[w[24:20]];
					npc = shadow_pc + 32'd4;
					immi = {{20{w[31]}}, w[31:20]};
					imms = {{20{w[31]}}, w[31:25], w[11:7]};
					immb = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
					immj = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
					case (op)
						OP_HALT: begin
							shadow_halt = 1'b1;
							npc = shadow_pc;
						end
						OP_REG: begin
							if (f3 == F3_ADD && f7 == F7_BASE) begin wr = 1'b1; val = a + b; end
							else if (f3 == F3_ADD && f7 == F7_ALT) begin wr = 1'b1; val = a - b; end
							else if (f7 == F7_BASE && f3 == F3_XOR) begin wr = 1'b1; val = a ^ b; end
							else if (f7 == F7_BASE && f3 == F3_OR) begin wr = 1'b1; val = a | b; end
							else if (f7 == F7_BASE && f3 == F3_AND) begin wr = 1'b1; val = a & b; end
						end
						OP_IMM: begin
							if (f3 == F3_ADD) begin wr = 1'b1; val = a + immi; end
							else if (f3 == F3_XOR) begin wr = 1'b1; val = a ^ immi; end
							else if (f3 == F3_OR) begin wr = 1'b1; val = a | immi; end
							else if (f3 == F3_AND) begin wr = 1'b1; val = a & immi; end
						end
						OP_LOAD: begin
							if (f3 == F3_WORD) begin
								wr = 1'b1;
								val = mem_word(a + immi);
								n_loads++;
							end
						end
						OP_STORE: begin
							if (f3 == F3_WORD) begin
								ea = (a + imms) % 32'(DATA_BYTES);
								for (int i = 0; i < 4; i++)
									shadow_mem[(ea + 32'(i)) % 32'(DATA_BYTES)] = b[31 - 8 * i -: 8];
								r.did_store = 1'b1;
								r.store_address = ea[9:0];
								r.store_value = b;
								n_stores++;
							end
						end
						OP_BRANCH: begin
							if ((f3 == F3_BEQ && a == b) || (f3 == F3_BNE && a != b)) begin
								npc = shadow_pc + immb;
								n_redirects++;
							end
						end
						OP_JAL: begin
							wr = 1'b1;
							val = shadow_pc + 32'd4;
							npc = shadow_pc + immj;
							n_redirects++;
						end
						default: ;
					endcase
					if (wr && rd != 5'd0) begin
						shadow_gpr[rd] = val;
						r.wrote_register = 1'b1;
						r.dest_index = rd;
						r.dest_value = val;
						n_reg_writes++;
					end
					shadow_pc = npc;
				end
			end
		endcase
		r.next_pc = shadow_pc;
		r.halted = shadow_halt;
		return r;
	endfunction

	function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
			input logic [4:0] rs1, input logic [2:0] f3, input logic [4:0] rd);
		return {f7, rs2, rs1, f3, rd, OP_REG};
	endfunction

	function automatic logic [31:0] enc_i(input logic [6:0] op, input logic [11:0] imm,
			input logic [4:0] rs1, input logic [2:0] f3, input logic [4:0] rd);
		return {imm, rs1, f3, rd, op};
	endfunction

	function automatic logic [31:0] enc_s(input logic [11:0] imm, input logic [4:0] rs2,
			input logic [4:0] rs1);
		return {imm[11:5], rs2, rs1, F3_WORD, imm[4:0], OP_STORE};
	endfunction

	function automatic logic [31:0] enc_b(input logic [12:0] imm, input logic [4:0] rs2,
			input logic [4:0] rs1, input logic [2:0] f3);
		return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
	endfunction

	function automatic logic [31:0] enc_j(input logic [20:0] imm, input logic [4:0] rd);
		return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
	endfunction

	task automatic add_item(input action_t act, input logic [31:0] w, input logic [9:0] addr,
			input logic [7:0] v, input logic [4:0] idx);
		item_t it;
		it.act = act;
		it.insn = w;
		it.baddr = addr;
		it.bval = v;
		it.ridx = idx;
		items_pending.push_back(it);
	endtask

	task automatic add_exec(input logic [31:0] w);
		add_item(ACT_EXEC, w, 10'($urandom), 8'($urandom), 5'($urandom));
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				results_due.push_back(run_on_shadow_cpu(on_bus));
				items_accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (items_pending.size() > 0 &&
						$urandom_range(99) >= ((items_accepted >= 350 && items_accepted < 470) ? 0 : 32)) begin
					on_bus = items_pending.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {1'b0, on_bus.ridx, on_bus.bval, on_bus.baddr, on_bus.insn};
					s_tuser <= on_bus.act;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		result_t want, got;
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left = 0;
			hold_done = 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (results_due.size() == 0) begin
					$display("%0t ns: unexpected result, expected none, actual %h", $time, m_tdata);
					errors++;
				end else begin
					want = results_due.pop_front();
					got = result_t'(m_tdata[OUT_FIELD_W-1:0]);
					check_field("next_pc", want.next_pc, got.next_pc);
					check_field("halted", 32'(want.halted), 32'(got.halted));
					check_field("wrote_register", 32'(want.wrote_register), 32'(got.wrote_register));
					check_field("dest_index", 32'(want.dest_index), 32'(got.dest_index));
					check_field("dest_value", want.dest_value, got.dest_value);
					check_field("did_store", 32'(want.did_store), 32'(got.did_store));
					check_field("store_address", 32'(want.store_address), 32'(got.store_address));
					check_field("store_value", want.store_value, got.store_value);
					check_field("read_data", want.read_data, got.read_data);
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!hold_done && results_seen >= 120) begin
				hold_done = 1'b1;
				hold_left = 400;
				m_tready <= 1'b0;
			end else begin
				m_tready <= $urandom_range(99) >= ((results_seen >= 350 && results_seen < 470) ? 0 : 32);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t ns: timeout, %0d of %0d transactions accepted, %0d results waiting",
				$time, items_accepted, items_total, results_due.size());
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		logic [31:0] w;
		logic [11:0] imm;
		logic [4:0] rd, rs1, rs2;
		int pick;

		for (int i = 0; i < REG_COUNT; i++)
			shadow_gpr[i] = '0;
		for (int i = 0; i < DATA_BYTES; i++)
			shadow_mem[i] = '0;
		shadow_pc = '0;
		shadow_halt = 1'b0;

		// field extremes and sign-extended immediates
		add_exec(enc_i(OP_IMM, 12'h7ff, 5'd0, F3_ADD, 5'd1));
		add_exec(enc_i(OP_IMM, 12'h800, 5'd0, F3_ADD, 5'd2));
		add_exec(enc_i(OP_IMM, 12'hfff, 5'd1, F3_XOR, 5'd3));
		add_exec(enc_i(OP_IMM, 12'h800, 5'd0, F3_OR, 5'd4));
		add_exec(enc_i(OP_IMM, 12'hff0, 5'd3, F3_AND, 5'd5));
		add_exec(enc_r(F7_BASE, 5'd2, 5'd1, F3_ADD, 5'd6));
		add_exec(enc_r(F7_ALT, 5'd1, 5'd2, F3_ADD, 5'd7));
		add_exec(enc_r(F7_BASE, 5'd4, 5'd3, F3_XOR, 5'd8));
		add_exec(enc_r(F7_BASE, 5'd4, 5'd1, F3_OR, 5'd9));
		add_exec(enc_r(F7_BASE, 5'd3, 5'd4, F3_AND, 5'd31));
		add_exec(enc_r(F7_BASE, 5'd1, 5'd1, F3_ADD, 5'd0));
		// stores and loads that wrap around the end of data memory
		add_exec(enc_s(12'hffc, 5'd4, 5'd0));
		add_exec(enc_s(12'd1022, 5'd3, 5'd0));
		add_exec(enc_i(OP_LOAD, 12'd1022, 5'd0, F3_WORD, 5'd11));
		add_exec(enc_i(OP_LOAD, 12'hffc, 5'd0, F3_WORD, 5'd12));
		add_item(ACT_WR_BYTE, '1, 10'd1023, 8'hff, 5'd31);
		add_item(ACT_RD_BYTE, '0, 10'd1023, 8'h00, 5'd0);
		add_item(ACT_RD_REG, '0, 10'd0, 8'h00, 5'd31);
		// branches taken and not, pc wrapping below zero, jal links
		add_exec(enc_b(13'h1000, 5'd0, 5'd0, F3_BEQ));
		add_exec(enc_b(13'h0ffe, 5'd2, 5'd1, F3_BNE));
		add_exec(enc_b(13'd8, 5'd2, 5'd1, F3_BEQ));
		add_exec(enc_b(13'd8, 5'd0, 5'd0, F3_BNE));
		add_exec(enc_j(21'h100000, 5'd31));
		add_exec(enc_j(21'h0ffffe, 5'd0));
		// encodings outside the subset only advance the pc
		add_exec(32'h0000_0000);
		add_exec(enc_r(7'h01, 5'd2, 5'd1, F3_ADD, 5'd13));
		add_exec(enc_i(OP_IMM, 12'h123, 5'd1, 3'd1, 5'd14));
		add_exec(enc_i(OP_LOAD, 12'h0, 5'd0, 3'd0, 5'd15));
		add_exec({7'h00, 5'd1, 5'd0, 3'd1, 5'd0, OP_STORE});
		add_exec(enc_b(13'd16, 5'd0, 5'd0, 3'd2));

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(99);
			if (pick < 8) begin
				add_item(ACT_WR_BYTE, $urandom, 10'($urandom), 8'($urandom), 5'($urandom));
			end else if (pick < 14) begin
				add_item(ACT_RD_BYTE, $urandom, 10'($urandom), 8'($urandom), 5'($urandom));
			end else if (pick < 20) begin
				add_item(ACT_RD_REG, $urandom, 10'($urandom), 8'($urandom), 5'($urandom));
			end else if (pick < 27) begin
				w = $urandom;
				if (w[6:0] == OP_HALT)
					w[6] = 1'b0;
				add_exec(w);
			end else begin
				rd = 5'($urandom);
				rs1 = 5'($urandom);
				rs2 = ($urandom_range(3) == 0) ? rs1 : 5'($urandom);
				imm = 12'($urandom);
				case ($urandom_range(13))
					0: w = enc_r(F7_BASE, rs2, rs1, F3_ADD, rd);
					1: w = enc_r(F7_ALT, rs2, rs1, F3_ADD, rd);
					2: w = enc_r(F7_BASE, rs2, rs1, F3_XOR, rd);
					3: w = enc_r(F7_BASE, rs2, rs1, F3_OR, rd);
					4: w = enc_r(F7_BASE, rs2, rs1, F3_AND, rd);
					5: w = enc_i(OP_IMM, imm, rs1, F3_ADD, rd);
					6: w = enc_i(OP_IMM, imm, rs1, F3_XOR, rd);
					7: w = enc_i(OP_IMM, imm, rs1, F3_OR, rd);
					8: w = enc_i(OP_IMM, imm, rs1, F3_AND, rd);
					9: w = enc_i(OP_LOAD, imm, rs1, F3_WORD, rd);
					10: w = enc_s(imm, rs2, rs1);
					11: w = enc_b(13'($urandom), rs2, rs1, F3_BEQ);
					12: w = enc_b(13'($urandom), rs2, rs1, F3_BNE);
					default: w = enc_j(21'($urandom), rd);
				endcase
				add_exec(w);
			end
		end

		// halt by either form, then confirm execution is frozen
		w = $urandom;
		w[6:0] = OP_HALT;
		if ($urandom_range(1) == 1)
			w = '1;
		else if (w == '1)
			w[31] = 1'b0;
		add_exec(w);
		add_exec('1);
		add_exec(enc_i(OP_IMM, 12'h001, 5'd0, F3_ADD, 5'd1));
		add_exec(enc_j(21'd64, 5'd2));
		add_exec(enc_s(12'd0, 5'd1, 5'd0));
		add_item(ACT_RD_REG, '0, 10'd0, 8'h00, 5'd1);
		add_item(ACT_WR_BYTE, '0, 10'd512, 8'h5a, 5'd0);
		add_item(ACT_RD_BYTE, '0, 10'd512, 8'h00, 5'd0);
		items_total = items_pending.size();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (items_accepted < items_total)
			@(posedge clk);
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("run covered %0d transactions, %0d results checked, %0d instructions executed",
			items_accepted, results_seen, n_exec);
		$display("register writes %0d, stores %0d, loads %0d, pc redirects %0d, halted %0d",
			n_reg_writes, n_stores, n_loads, n_redirects, shadow_halt);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
